### hdl/eols_pkg.sv
// Shared types and constants for the end-of-line detector and line splitter.
// Holds the input and result item structs and the character/terminator codes.
// No dependencies.
`default_nettype none
package eols_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 24;
  localparam int unsigned FIELD_W         = 24;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h00;

  localparam logic [2:0] TERM_NONE = 3'd0;
  localparam logic [2:0] TERM_CR   = 3'd1;
  localparam logic [2:0] TERM_LF   = 3'd2;
  localparam logic [2:0] TERM_CRLF = 3'd3;
  localparam logic [2:0] TERM_ZERO = 3'd4;

  localparam logic [1:0] EOL_CR   = 2'd0;
  localparam logic [1:0] EOL_LF   = 2'd1;
  localparam logic [1:0] EOL_CRLF = 2'd2;

  localparam logic KIND_LINE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Most results one input item can cause
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_only;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] line_start;
    logic [FIELD_W-1:0] line_length;
    logic [2:0]         terminator;
    logic [FIELD_W-1:0] line_index;
    logic [1:0]         eol_type;
    logic [FIELD_W-1:0] cr_total;
    logic [FIELD_W-1:0] lf_total;
    logic [FIELD_W-1:0] crlf_total;
    logic [FIELD_W-1:0] zero_total;
    logic [FIELD_W-1:0] line_total;
    logic               last_result;
  } out_item_t;

endpackage
`default_nettype wire

### hdl/eols_split.sv
// Line splitting state and per-item logic: offsets, pending CR, terminator
// counters and the end-of-file summary. Produces up to three results per item.
// Depends on eols_pkg.
`default_nettype none
module eols_split #(
  parameter int unsigned OFFSET_BITS = eols_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    step,
  input  wire eols_pkg::in_item_t                      item,
  input  wire logic [1:0]                              dflt_eol,
  output eols_pkg::out_item_t [eols_pkg::MAX_RES-1:0]  res,
  output logic [1:0]                                   res_n
);

  localparam int unsigned FW = eols_pkg::FIELD_W;
  localparam int unsigned WX = (OFFSET_BITS > FW) ? OFFSET_BITS : FW;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);
  localparam logic [FW-1:0] CNT_MAX = {FW{1'b1}};

  typedef struct packed {
    logic [FW-1:0] cr;
    logic [FW-1:0] lf;
    logic [FW-1:0] crlf;
    logic [FW-1:0] zero;
    logic [FW-1:0] lines;
  } cnt_t;

  logic                   pcr_r, pcr_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] st_r, st_nxt;
  cnt_t                   cnt_r, cnt_nxt;

  function automatic logic [OFFSET_BITS-1:0] inc_off(input logic [OFFSET_BITS-1:0] v);
    return (v == OFF_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] diff0(input logic [OFFSET_BITS-1:0] a,
                                                   input logic [OFFSET_BITS-1:0] b);
    return (a >= b) ? a - b : '0;
  endfunction

  function automatic logic [FW-1:0] to_field(input logic [OFFSET_BITS-1:0] v);
    logic [WX-1:0] t;
    t = WX'(v);
    return t[FW-1:0];
  endfunction

  function automatic logic [FW-1:0] inc_cnt(input logic [FW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic cnt_t bump(input cnt_t c, input logic [2:0] term);
    cnt_t r;
    r = c;
    r.lines = inc_cnt(c.lines);
    case (term)
      eols_pkg::TERM_CR:   r.cr   = inc_cnt(c.cr);
      eols_pkg::TERM_LF:   r.lf   = inc_cnt(c.lf);
      eols_pkg::TERM_CRLF: r.crlf = inc_cnt(c.crlf);
      eols_pkg::TERM_ZERO: r.zero = inc_cnt(c.zero);
      default:             r.lines = r.lines;
    endcase
    return r;
  endfunction

  function automatic eols_pkg::out_item_t mk_line(input logic [OFFSET_BITS-1:0] st,
                                                  input logic [OFFSET_BITS-1:0] len,
                                                  input logic [2:0] term,
                                                  input logic [FW-1:0] idx);
    eols_pkg::out_item_t r;
    r             = '0;
    r.kind        = eols_pkg::KIND_LINE;
    r.line_start  = to_field(st);
    r.line_length = to_field(len);
    r.terminator  = term;
    r.line_index  = idx;
    return r;
  endfunction

  // Majority rule; the CRLF check overrides the CR check
  function automatic logic [1:0] decide(input cnt_t c, input logic [1:0] dflt);
    logic [1:0] t;
    t = (dflt == 2'd3) ? eols_pkg::EOL_LF : dflt;
    if (c.cr > c.lf) begin
      if (c.cr > c.crlf) t = eols_pkg::EOL_CR;
      if (c.crlf > c.lf) t = eols_pkg::EOL_CRLF;
    end else begin
      if (c.lf > c.crlf) t = eols_pkg::EOL_LF;
      if (c.crlf > c.lf) t = eols_pkg::EOL_CRLF;
    end
    return t;
  endfunction

  always_comb begin
    logic [OFFSET_BITS-1:0] q;
    logic [OFFSET_BITS-1:0] st;
    logic                   pcr;
    logic                   consumed;
    cnt_t                   c;
    logic [1:0]             n;
    eols_pkg::out_item_t    sm;
    q        = pos_r;
    st       = st_r;
    pcr      = pcr_r;
    c        = cnt_r;
    consumed = 1'b0;
    n        = '0;
    res      = '0;
    sm       = '0;
    if (!item.end_only) begin
      if (pcr) begin
        pcr = 1'b0;
        if (item.data_byte == eols_pkg::CH_LF) begin
          res[n] = mk_line(st, diff0(diff0(q, OFF_ONE), st), eols_pkg::TERM_CRLF, c.lines);
          c = bump(c, eols_pkg::TERM_CRLF);
          n = n + 2'd1;
          st = inc_off(q);
          consumed = 1'b1;
        end else begin
          res[n] = mk_line(st, diff0(diff0(q, OFF_ONE), st), eols_pkg::TERM_CR, c.lines);
          c = bump(c, eols_pkg::TERM_CR);
          n = n + 2'd1;
          st = q;
        end
      end
      if (!consumed) begin
        if (item.data_byte == eols_pkg::CH_ZERO) begin
          res[n] = mk_line(st, diff0(q, st), eols_pkg::TERM_ZERO, c.lines);
          c = bump(c, eols_pkg::TERM_ZERO);
          n = n + 2'd1;
          st = inc_off(q);
        end else if (item.data_byte == eols_pkg::CH_CR) begin
          pcr = 1'b1;
        end else if (item.data_byte == eols_pkg::CH_LF) begin
          res[n] = mk_line(st, diff0(q, st), eols_pkg::TERM_LF, c.lines);
          c = bump(c, eols_pkg::TERM_LF);
          n = n + 2'd1;
          st = inc_off(q);
        end
      end
      q = inc_off(q);
    end
    if (item.last) begin
      // Close a held CR, else flush an unterminated tail
      if (pcr) begin
        pcr = 1'b0;
        res[n] = mk_line(st, diff0(diff0(q, OFF_ONE), st), eols_pkg::TERM_CR, c.lines);
        c = bump(c, eols_pkg::TERM_CR);
        n = n + 2'd1;
        st = q;
      end else if (q > st) begin
        res[n] = mk_line(st, q - st, eols_pkg::TERM_NONE, c.lines);
        c = bump(c, eols_pkg::TERM_NONE);
        n = n + 2'd1;
      end
      sm.kind        = eols_pkg::KIND_SUMMARY;
      sm.eol_type    = decide(c, dflt_eol);
      sm.cr_total    = c.cr;
      sm.lf_total    = c.lf;
      sm.crlf_total  = c.crlf;
      sm.zero_total  = c.zero;
      sm.line_total  = c.lines;
      sm.last_result = 1'b1;
      res[n] = sm;
      n = n + 2'd1;
      // File done: drop back to reset state
      pcr = 1'b0;
      q   = '0;
      st  = '0;
      c   = '0;
    end
    res_n   = n;
    pcr_nxt = pcr;
    pos_nxt = q;
    st_nxt  = st;
    cnt_nxt = c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcr_r <= 1'b0;
      pos_r <= '0;
      st_r  <= '0;
      cnt_r <= '0;
    end else if (step) begin
      pcr_r <= pcr_nxt;
      pos_r <= pos_nxt;
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_last_gives_summary: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last |-> res_n != 2'd0 && res[res_n - 2'd1].kind == eols_pkg::KIND_SUMMARY)
    else $error("last item without trailing summary");
  a_plain_item_short: assert property (@(posedge clk) disable iff (!rst_n)
    step && !item.last |-> res_n <= 2'd2)
    else $error("non-final item produced too many results");
  a_file_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last |=> pos_r == '0 && st_r == '0 && !pcr_r && cnt_r.lines == '0)
    else $error("file state not cleared after last item");
`endif

endmodule
`default_nettype wire

### hdl/eols_rq.sv
// Result queue: four entries, takes up to three results in one cycle and
// hands out one per cycle while out_ready is high. Depends on eols_pkg.
`default_nettype none
module eols_rq (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire eols_pkg::out_item_t [eols_pkg::MAX_RES-1:0] push_data,
  input  wire logic [1:0]                              push_n,
  output logic                                         room,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output eols_pkg::out_item_t                          out_item
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  eols_pkg::out_item_t q_r [DEPTH];
  logic [AW-1:0]       wr_r, wr_nxt;
  logic [AW-1:0]       rd_r, rd_nxt;
  logic [AW:0]         cnt_r, cnt_nxt;
  logic                pop;

  assign out_valid = (cnt_r != '0);
  assign out_item  = q_r[rd_r];
  assign pop       = out_valid && out_ready;
  // Room for a full burst of results once this cycle's pop is counted
  assign room      = (cnt_r <= (AW+1)'(1)) || (cnt_r == (AW+1)'(2) && pop);

  always_comb begin
    wr_nxt  = wr_r + AW'(push_n);
    rd_nxt  = rd_r + AW'(pop);
    cnt_nxt = cnt_r + (AW+1)'(push_n) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < eols_pkg::MAX_RES; i++) begin
      if (2'(i) < push_n) begin
        q_r[wr_r + AW'(i)] <= push_data[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH))
    else $error("result queue overfilled");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |-> room)
    else $error("results pushed without room");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != (AW+1)'(DEPTH) |-> AW'(wr_r - rd_r) == cnt_r[AW-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

### hdl/eol_detect_line_splitter_unit.sv
// Throughput: one item per cycle while out_ready is high and items give at
//   most one result each; the four-entry result queue drains one result per
//   cycle while out_ready is high, so an item that gives two or three results
//   holds the input until the queue has room.
// Reset: synchronous active-low rst_n clears file state, queue and input stage;
//   the default end-of-line type returns to LF.
`default_nettype none
module eol_detect_line_splitter_unit #(
  parameter int unsigned OFFSET_BITS = eols_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire eols_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output eols_pkg::out_item_t      out_item,
  input  wire logic                cfg_wr_en,
  input  wire logic [1:0]          cfg_wr_data
);

  logic                v_r, v_nxt;
  eols_pkg::in_item_t  item_r;
  logic [1:0]          dflt_r;
  logic                room;
  logic                adv;
  logic                fire;
  eols_pkg::out_item_t [eols_pkg::MAX_RES-1:0] res;
  logic [1:0]          res_n;
  logic [1:0]          push_n;

  assign adv      = v_r && room;
  assign in_ready = !v_r || adv;
  assign fire     = in_valid && in_ready;
  assign push_n   = adv ? res_n : 2'd0;

  always_comb begin
    v_nxt = v_r;
    if (fire) begin
      v_nxt = 1'b1;
    end else if (adv) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      dflt_r <= eols_pkg::EOL_LF;
    end else begin
      v_r <= v_nxt;
      if (cfg_wr_en) begin
        dflt_r <= cfg_wr_data;
      end
    end
  end

  // Hold the item until the split stage takes it
  always_ff @(posedge clk) begin
    if (fire) begin
      item_r <= in_item;
    end
  end

  eols_split #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .item     (item_r),
    .dflt_eol (dflt_r),
    .res      (res),
    .res_n    (res_n)
  );

  eols_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_data (res),
    .push_n    (push_n),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && !room |=> v_r && $stable(item_r))
    else $error("input stage lost a waiting item");
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && !room |-> !in_ready)
    else $error("input accepted while stage is blocked");
  a_adv_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item_r.last |-> push_n != 2'd0)
    else $error("final item advanced with no results");
`endif

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for eol_detect_line_splitter_unit: feeds files byte by byte and
// checks each line descriptor and end-of-file summary against a local predictor.
// Depends on eols_pkg and the unit under test only.
module testbench;
  import eols_pkg::*;

  localparam int ITEMS_TOTAL   = 430;
  localparam int N_PHASES      = 6;
  localparam int N_DIRECTED    = 23;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTED  = 10;
  localparam logic [1:0] EOL_UNUSED = 2'd3;
  localparam logic [1:0] PHASE_EOL [4] = '{EOL_CR, EOL_CRLF, EOL_UNUSED, EOL_LF};

  typedef struct {
    in_item_t  it;
    logic      pinned;
    out_item_t want;
  } probe_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = '0;

  eol_detect_line_splitter_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: one file in progress plus the default type register
  logic [1:0]         dflt_eol = EOL_LF;
  logic               cr_waiting = 1'b0;
  logic [FIELD_W-1:0] byte_pos = '0;
  logic [FIELD_W-1:0] line_head = '0;
  logic [FIELD_W-1:0] n_cr = '0;
  logic [FIELD_W-1:0] n_lf = '0;
  logic [FIELD_W-1:0] n_crlf = '0;
  logic [FIELD_W-1:0] n_zero = '0;
  logic [FIELD_W-1:0] n_lines = '0;

  out_item_t due_reports[$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        feed_calm = 0;
  bit        squeeze = 1'b0;
  probe_t    directed [N_DIRECTED];

  function automatic logic [FIELD_W-1:0] bump(logic [FIELD_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [FIELD_W-1:0] floor_sub(logic [FIELD_W-1:0] a,
                                                    logic [FIELD_W-1:0] b);
    return (a >= b) ? a - b : '0;
  endfunction

  function automatic in_item_t mk_item(logic [7:0] b, logic eo, logic la);
    in_item_t it;
    it.data_byte = b;
    it.end_only  = eo;
    it.last      = la;
    return it;
  endfunction

  function automatic out_item_t line_desc(int start, int len, logic [2:0] term, int idx);
    out_item_t r;
    r = '0;
    r.kind        = KIND_LINE;
    r.line_start  = FIELD_W'(start);
    r.line_length = FIELD_W'(len);
    r.terminator  = term;
    r.line_index  = FIELD_W'(idx);
    return r;
  endfunction

  function automatic out_item_t tally(logic [1:0] eol, int cr, int lf, int crlf,
                                     int zero, int lines);
    out_item_t r;
    r = '0;
    r.kind        = KIND_SUMMARY;
    r.eol_type    = eol;
    r.cr_total    = FIELD_W'(cr);
    r.lf_total    = FIELD_W'(lf);
    r.crlf_total  = FIELD_W'(crlf);
    r.zero_total  = FIELD_W'(zero);
    r.line_total  = FIELD_W'(lines);
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic void close_line(logic [FIELD_W-1:0] len, logic [2:0] term);
    due_reports.push_back(line_desc(int'(line_head), int'(len), term, int'(n_lines)));
    n_lines = bump(n_lines);
    case (term)
      TERM_CR:   n_cr   = bump(n_cr);
      TERM_LF:   n_lf   = bump(n_lf);
      TERM_CRLF: n_crlf = bump(n_crlf);
      TERM_ZERO: n_zero = bump(n_zero);
      default: ;
    endcase
  endfunction

  function automatic logic [1:0] majority_eol();
    logic [1:0] t;
    logic       hit;
    hit = 1'b0;
    t   = EOL_LF;
    if (n_cr > n_lf) begin
      if (n_cr > n_crlf) begin
        t = EOL_CR;
        hit = 1'b1;
      end
      if (n_crlf > n_lf) begin
        t = EOL_CRLF;
        hit = 1'b1;
      end
    end else begin
      if (n_lf > n_crlf) begin
        t = EOL_LF;
        hit = 1'b1;
      end
      if (n_crlf > n_lf) begin
        t = EOL_CRLF;
        hit = 1'b1;
      end
    end
    if (!hit) t = (dflt_eol == EOL_UNUSED) ? EOL_LF : dflt_eol;
    return t;
  endfunction

  // Advance the file state by one item and queue the results it causes
  function automatic void split_and_tally(in_item_t it);
    logic [FIELD_W-1:0] q;
    logic               took;
    if (!it.end_only) begin
      q = byte_pos;
      took = 1'b0;
      if (cr_waiting) begin
        cr_waiting = 1'b0;
        if (it.data_byte == CH_LF) begin
          close_line(floor_sub(floor_sub(q, FIELD_W'(1)), line_head), TERM_CRLF);
          line_head = bump(q);
          took = 1'b1;
        end else begin
          close_line(floor_sub(floor_sub(q, FIELD_W'(1)), line_head), TERM_CR);
          line_head = q;
        end
      end
      if (!took) begin
        case (it.data_byte)
          CH_ZERO: begin
            close_line(floor_sub(q, line_head), TERM_ZERO);
            line_head = bump(q);
          end
          CH_CR: cr_waiting = 1'b1;
          CH_LF: begin
            close_line(floor_sub(q, line_head), TERM_LF);
            line_head = bump(q);
          end
          default: ;
        endcase
      end
      byte_pos = bump(q);
    end
    if (it.last) begin
      if (cr_waiting) begin
        cr_waiting = 1'b0;
        close_line(floor_sub(floor_sub(byte_pos, FIELD_W'(1)), line_head), TERM_CR);
        line_head = byte_pos;
      end else if (byte_pos > line_head) begin
        close_line(byte_pos - line_head, TERM_NONE);
      end
      due_reports.push_back(tally(majority_eol(), int'(n_cr), int'(n_lf), int'(n_crlf),
                                  int'(n_zero), int'(n_lines)));
      byte_pos = '0;
      line_head = '0;
      n_cr = '0;
      n_lf = '0;
      n_crlf = '0;
      n_zero = '0;
      n_lines = '0;
    end
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTED) $display("mismatch at %0t:%s", $realtime, msg);
  endfunction

  function automatic string field_diff(out_item_t w, out_item_t g);
    string s;
    s = "";
    if (g.kind !== w.kind)
      s = {s, $sformatf(" kind exp %0d got %0d", w.kind, g.kind)};
    if (g.line_start !== w.line_start)
      s = {s, $sformatf(" line_start exp %0d got %0d", w.line_start, g.line_start)};
    if (g.line_length !== w.line_length)
      s = {s, $sformatf(" line_length exp %0d got %0d", w.line_length, g.line_length)};
    if (g.terminator !== w.terminator)
      s = {s, $sformatf(" terminator exp %0d got %0d", w.terminator, g.terminator)};
    if (g.line_index !== w.line_index)
      s = {s, $sformatf(" line_index exp %0d got %0d", w.line_index, g.line_index)};
    if (g.eol_type !== w.eol_type)
      s = {s, $sformatf(" eol_type exp %0d got %0d", w.eol_type, g.eol_type)};
    if (g.cr_total !== w.cr_total)
      s = {s, $sformatf(" cr_total exp %0d got %0d", w.cr_total, g.cr_total)};
    if (g.lf_total !== w.lf_total)
      s = {s, $sformatf(" lf_total exp %0d got %0d", w.lf_total, g.lf_total)};
    if (g.crlf_total !== w.crlf_total)
      s = {s, $sformatf(" crlf_total exp %0d got %0d", w.crlf_total, g.crlf_total)};
    if (g.zero_total !== w.zero_total)
      s = {s, $sformatf(" zero_total exp %0d got %0d", w.zero_total, g.zero_total)};
    if (g.line_total !== w.line_total)
      s = {s, $sformatf(" line_total exp %0d got %0d", w.line_total, g.line_total)};
    if (g.last_result !== w.last_result)
      s = {s, $sformatf(" last_result exp %0d got %0d", w.last_result, g.last_result)};
    return s;
  endfunction

  // Offer one item and hold it until accepted; valid stays high for a
  // back-to-back follower
  task automatic push_item(input in_item_t it);
    int wait_cyc;
    wait_cyc = squeeze ? 0 : draw_wait(feed_calm);
    if (wait_cyc > 0) begin
      in_valid <= 1'b0;
      repeat (wait_cyc) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    if (!(it.end_only && !it.last)) items_sent++;
    split_and_tally(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_default_eol(input logic [1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dflt_eol = v;
  endtask

  function automatic logic [2:0] pick_term(int flavor);
    int pick;
    pick = (flavor < 3 && $urandom_range(0, 9) < 7) ? flavor : $urandom_range(0, 3);
    case (pick)
      0: return TERM_CR;
      1: return TERM_LF;
      2: return TERM_CRLF;
      default: return TERM_ZERO;
    endcase
  endfunction

  function automatic in_item_t text_item();
    if ($urandom_range(0, 3) != 0) return mk_item(8'($urandom_range(32, 126)), 1'b0, 1'b0);
    return mk_item(8'($urandom_range(128, 255)), 1'b0, 1'b0);
  endfunction

  // Build one file: mostly lines, often with a favored terminator, sometimes raw noise
  task automatic send_random_file();
    in_item_t   body[$];
    int         flavor;
    logic [2:0] term;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(0, 12))
        body.push_back(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
    end else begin
      flavor = $urandom_range(0, 3);
      repeat ($urandom_range(0, 6)) begin
        repeat ($urandom_range(0, 5)) body.push_back(text_item());
        term = pick_term(flavor);
        case (term)
          TERM_CR:   body.push_back(mk_item(CH_CR, 1'b0, 1'b0));
          TERM_LF:   body.push_back(mk_item(CH_LF, 1'b0, 1'b0));
          TERM_CRLF: begin
            body.push_back(mk_item(CH_CR, 1'b0, 1'b0));
            body.push_back(mk_item(CH_LF, 1'b0, 1'b0));
          end
          default:   body.push_back(mk_item(CH_ZERO, 1'b0, 1'b0));
        endcase
      end
      if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 4)) body.push_back(text_item());
    end
    // byte-less filler items do nothing mid-file
    if ($urandom_range(0, 3) == 0)
      body.insert($urandom_range(0, body.size()),
                  mk_item(8'($urandom_range(0, 255)), 1'b1, 1'b0));
    if (body.size() != 0 && $urandom_range(0, 1) == 1)
      body[body.size() - 1].last = 1'b1;
    else
      body.push_back(mk_item(8'($urandom_range(0, 255)), 1'b1, 1'b1));
    foreach (body[i]) push_item(body[i]);
  endtask

  initial begin : stimulus
    int phase;
    directed = '{
      '{mk_item(8'hA5, 1'b1, 1'b1), 1'b1, tally(EOL_LF, 0, 0, 0, 0, 0)},
      '{mk_item(8'h61, 1'b0, 1'b0), 1'b0, '0},
      '{mk_item(CH_CR, 1'b0, 1'b0), 1'b0, '0},
      '{mk_item(CH_LF, 1'b0, 1'b0), 1'b1, line_desc(0, 1, TERM_CRLF, 0)},
      '{mk_item(8'h62, 1'b0, 1'b0), 1'b0, '0},
      '{mk_item(CH_CR, 1'b0, 1'b0), 1'b0, '0},
      '{mk_item(8'h63, 1'b0, 1'b0), 1'b0, '0},
      '{mk_item(CH_LF, 1'b0, 1'b0), 1'b0, '0},
      '{mk_item(CH_ZERO, 1'b0, 1'b0), 1'b1, line_desc(7, 0, TERM_ZERO, 3)},
      '{mk_item(8'hFF, 1'b1, 1'b0), 1'b0, '0},
      '{mk_item(8'hFF, 1'b0, 1'b1), 1'b0, '0},
      '{mk_item(CH_CR, 1'b0, 1'b1), 1'b0, '0},
      '{mk_item(CH_CR, 1'b0, 1'b0), 1'b0, '0},
      '{mk_item(CH_CR, 1'b0, 1'b0), 1'b0, '0},
      '{mk_item(CH_LF, 1'b0, 1'b1), 1'b0, '0},
      '{mk_item(CH_CR, 1'b0, 1'b0), 1'b0, '0},
      '{mk_item(CH_ZERO, 1'b0, 1'b0), 1'b0, '0},
      '{mk_item(CH_CR, 1'b1, 1'b1), 1'b0, '0},
      '{mk_item(8'h78, 1'b0, 1'b0), 1'b0, '0},
      '{mk_item(CH_CR, 1'b0, 1'b0), 1'b0, '0},
      '{mk_item(CH_ZERO, 1'b0, 1'b1), 1'b0, '0},
      '{mk_item(CH_LF, 1'b0, 1'b1), 1'b0, '0},
      '{mk_item(8'h7A, 1'b0, 1'b1), 1'b0, '0}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      push_item(directed[i].it);
      // a pinned row causes exactly one result: take the typed-in value
      if (directed[i].pinned) due_reports[due_reports.size() - 1] = directed[i].want;
    end

    for (phase = 0; phase < N_PHASES; phase++) begin
      drain_results();
      set_default_eol(phase < 4 ? PHASE_EOL[phase] : 2'($urandom_range(0, 3)));
      push_item(mk_item(8'($urandom_range(0, 255)), 1'b1, 1'b1));
      if (phase == 1) begin
        // back up the result queue while the sink holds off
        squeeze = 1'b1;
        repeat (40) push_item(mk_item(CH_LF, 1'b0, 1'b0));
        push_item(mk_item(8'h41, 1'b0, 1'b1));
      end
      while (items_sent < ITEMS_TOTAL * (phase + 1) / N_PHASES) send_random_file();
    end
    drain_results();

    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : result_sink
    int calm;
    int wait_cyc;
    calm = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze = 1'b0;
      end
      wait_cyc = draw_wait(calm);
      if (wait_cyc > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cyc) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    string     diffs;
    if (rst_n && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        report_mismatch($sformatf(" unexpected result %p", out_item));
      end else begin
        want  = due_reports.pop_front();
        diffs = field_diff(want, out_item);
        if (diffs != "") report_mismatch(diffs);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### files.f
hdl/eols_pkg.sv
hdl/eols_split.sv
hdl/eols_rq.sv
hdl/eol_detect_line_splitter_unit.sv
dv/testbench.sv
